// ===== rtl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  // Heap geometry.
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Request codes on req_type.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture the request and update the count
    logic up_rd;      // read the parent of the hole
    logic up_step;    // move the parent down into the hole
    logic dn_rd_ends; // read the root and the last element
    logic dn_load;    // latch the minimum and the moving element
    logic dn_rd_kids; // read both children of the hole
    logic dn_step;    // move the smaller child up into the hole
    logic fin_wr;     // write the moving element into the hole
    logic out_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_insert;
    logic err;
    logic pos_zero;
    logic up_less;
    logic dn_leaf;
    logic dn_less;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bmhq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhq_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire bmhq_pkg::cmd_t                 cmd,
  output bmhq_pkg::sts_t                      sts,
  input  wire logic                           req_type,
  input  wire logic signed [bmhq_pkg::DATA_W-1:0] value,
  output logic signed [bmhq_pkg::DATA_W-1:0]  min_value,
  output logic [1:0]                          status,
  output logic [bmhq_pkg::CNT_W-1:0]          count
);
  import bmhq_pkg::*;

  // Heap storage, two registered read ports and one write port.
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic              we;
  logic [DATA_W-1:0] wdata;

  logic [CNT_W-1:0]  heap_count;
  logic [ADDR_W-1:0] pos;
  logic [DATA_W-1:0] mv;
  logic [DATA_W-1:0] minv;
  status_t           stat;
  logic              is_insert;

  logic [ADDR_W-1:0] par_idx;
  logic [ADDR_W+1:0] l_idx;
  logic [ADDR_W+1:0] r_idx;
  logic [ADDR_W+1:0] cnt_ext;
  logic              take_right;
  logic [DATA_W-1:0] pick_val;
  logic [ADDR_W-1:0] pick_idx;

  assign par_idx    = (pos - ADDR_W'(1)) >> 1;
  assign l_idx      = {1'b0, pos, 1'b1};
  assign r_idx      = l_idx + (ADDR_W+2)'(1);
  assign cnt_ext    = (ADDR_W+2)'(heap_count);
  assign take_right = (r_idx < cnt_ext) && ($signed(rd_b) < $signed(rd_a));
  assign pick_val   = take_right ? rd_b : rd_a;
  assign pick_idx   = take_right ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];

  always_comb begin
    raddr_a = '0;
    raddr_b = r_idx[ADDR_W-1:0];
    if (cmd.dn_rd_ends) begin
      raddr_b = heap_count[ADDR_W-1:0];
    end else if (cmd.up_rd) begin
      raddr_a = par_idx;
    end else if (cmd.dn_rd_kids) begin
      raddr_a = l_idx[ADDR_W-1:0];
    end
  end

  always_comb begin
    we    = cmd.up_step | cmd.dn_step | cmd.fin_wr;
    wdata = mv;
    if (cmd.up_step) begin
      wdata = rd_a;
    end else if (cmd.dn_step) begin
      wdata = pick_val;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
    if (we) begin
      mem[pos] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count <= '0;
    end else if (cmd.accept) begin
      if (req_type == REQ_INSERT) begin
        if (heap_count != CNT_W'(CAPACITY)) begin
          heap_count <= heap_count + CNT_W'(1);
        end
      end else if (heap_count != '0) begin
        heap_count <= heap_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_insert <= (req_type == REQ_INSERT);
      mv        <= value;
      minv      <= '0;
      pos       <= heap_count[ADDR_W-1:0];
      if (req_type == REQ_INSERT) begin
        stat <= (heap_count == CNT_W'(CAPACITY)) ? ST_FULL : ST_OK;
      end else begin
        stat <= (heap_count == '0) ? ST_EMPTY : ST_OK;
      end
    end else if (cmd.up_step) begin
      pos <= par_idx;
    end else if (cmd.dn_load) begin
      minv <= rd_a;
      mv   <= rd_b;
      pos  <= '0;
    end else if (cmd.dn_step) begin
      pos <= pick_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      min_value <= minv;
      status    <= stat;
      count     <= heap_count;
    end
  end

  always_comb begin
    sts.is_insert = is_insert;
    sts.err       = (stat != ST_OK);
    sts.pos_zero  = (pos == '0);
    sts.up_less   = ($signed(mv) < $signed(rd_a));
    sts.dn_leaf   = (l_idx >= cnt_ext);
    sts.dn_less   = ($signed(pick_val) < $signed(mv));
  end

endmodule

`default_nettype wire

// ===== rtl/bmhq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire bmhq_pkg::sts_t sts,
  output bmhq_pkg::cmd_t      cmd
);
  import bmhq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_UP_CHK   = 9'b000000100,
    S_UP_CMP   = 9'b000001000,
    S_DN_RD    = 9'b000010000,
    S_DN_LD    = 9'b000100000,
    S_DN_CHK   = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.err) begin
          state_next = S_DONE;
        end else if (sts.is_insert) begin
          state_next = S_UP_CHK;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_UP_CHK: begin
        if (sts.pos_zero) begin
          cmd.fin_wr = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.up_rd  = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.up_step = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          cmd.fin_wr = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DN_RD: begin
        cmd.dn_rd_ends = 1'b1;
        state_next     = S_DN_LD;
      end
      S_DN_LD: begin
        cmd.dn_load = 1'b1;
        state_next  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.dn_leaf) begin
          cmd.fin_wr = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.dn_rd_kids = 1'b1;
          state_next     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_less) begin
          cmd.dn_step = 1'b1;
          state_next  = S_DN_CHK;
        end else begin
          cmd.fin_wr = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DISPATCH)
    else $error("accepted request did not move to dispatch");

  a_err_short: assert property (@(posedge clk) disable iff (rst)
    state == S_DISPATCH && sts.err |=> state == S_DONE)
    else $error("rejected request entered a sift");

  a_up_stop: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CMP && !sts.up_less |=> state == S_DONE)
    else $error("sift up continued past a smaller parent");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!out_valid || out_ready) |=> out_valid && state == S_IDLE)
    else $error("finished result was not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/binary_min_heap_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Binary min-heap priority queue over signed 32-bit values, up to 256 entries.
// Requests arrive on the input channel (in_valid/in_ready) carrying req_type
// and value: insert places the value at the end of the heap and sifts it up,
// extract returns the root and sifts the last element down from the root.
// Every request gives exactly one result transaction on the output channel
// (out_valid/out_ready) with min_value, status and the element count after
// the operation. Extract from an empty heap and insert into a full heap leave
// the heap unchanged and report their status with min_value zero.
// One request is in progress at a time; in_ready is high only while the
// sequencer is idle. The heap memory has two read ports and one write port,
// and each level of a sift has a read step and a compare/write step. An insert
// climbs until the value reaches the root or meets a parent no greater than it;
// an extract descends until the moved element reaches a leaf or has no smaller
// child; a rejected request skips the sift. The sequencer is ready for the next
// request in the cycle after it loads the result. The result waits in its own
// register; a stalled receiver holds the sequencer in its last state only once
// the next result is ready. Reset empties the heap and drops any pending result;
// the memory needs no clearing since only entries below the count are read.
module binary_min_heap_queue_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  req_type,
  input  wire logic signed [bmhq_pkg::DATA_W-1:0]    value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [bmhq_pkg::DATA_W-1:0]         min_value,
  output logic [1:0]                                 status,
  output logic [bmhq_pkg::CNT_W-1:0]                 count
);
  import bmhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: handshakes, sift loop control and the result valid flag.
  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Heap memory, count, hole position, comparators and result payload.
  bmhq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (req_type),
    .value     (value),
    .min_value (min_value),
    .status    (status),
    .count     (count)
  );

endmodule

`default_nettype wire
